### design/hwrgb_pkg.sv
// shared constants, types and the ramp function of the hue wheel colour block
package hwrgb_pkg;

   localparam int WINDOW_LEN = 6;
   localparam int WIN_POS_W  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;

   localparam int SAMPLE_W = 14;
   localparam int DUTY_W   = 7;
   localparam int SLOPE_W  = 13;
   localparam int OFFS_W   = 10;
   localparam int PROD_W   = SAMPLE_W + SLOPE_W;
   localparam int ACC_W    = PROD_W + 2;

   typedef logic [SAMPLE_W-1:0]      sample_type;
   typedef logic [DUTY_W-1:0]        duty_type;
   typedef logic [WIN_POS_W-1:0]     win_pos_type;
   typedef logic [SLOPE_W-1:0]       slope_type;
   typedef logic signed [OFFS_W-1:0] offset_type;

   typedef struct packed {
      duty_type red;
      duty_type green;
      duty_type blue;
   } colour_type;

   localparam sample_type SPLIT_RESET = SAMPLE_W'(5000);

   // segment upper bounds of the wheel
   localparam sample_type SEG0_TOP = SAMPLE_W'(1250);
   localparam sample_type SEG1_TOP = SAMPLE_W'(2500);
   localparam sample_type SEG2_TOP = SAMPLE_W'(4250);
   localparam sample_type SEG3_TOP = SAMPLE_W'(6000);
   localparam sample_type SEG4_TOP = SAMPLE_W'(8000);
   localparam sample_type SEG5_TOP = SAMPLE_W'(10000);

   // unsigned q0.16 slopes, truncated
   localparam slope_type SLOPE_008   = SLOPE_W'(5242);
   localparam slope_type SLOPE_05714 = SLOPE_W'(3744);
   localparam slope_type SLOPE_005   = SLOPE_W'(3276);

   localparam offset_type OFFS_ZERO     = OFFS_W'(0);
   localparam offset_type OFFS_RED_FALL = OFFS_W'(200);
   localparam offset_type OFFS_BLU_RISE = -OFFS_W'(143);
   localparam offset_type OFFS_GRN_FALL = OFFS_W'(343);
   localparam offset_type OFFS_RED_RISE = -OFFS_W'(300);
   localparam offset_type OFFS_BLU_FALL = OFFS_W'(500);

   localparam duty_type DUTY_FULL = DUTY_W'(100);
   localparam duty_type DUTY_NONE = DUTY_W'(0);

   // offset +/- slope * p in signed q13.16, floored at zero, truncated, clamped to full duty
   function automatic duty_type ramp(input offset_type offset, input logic rising,
                                     input slope_type slope, input sample_type p);
      logic [PROD_W-1:0]       prod;
      logic signed [ACC_W-1:0] base;
      logic signed [ACC_W-1:0] acc;
      logic [ACC_W-18:0]       whole;
      duty_type                res;
      prod  = PROD_W'(slope) * PROD_W'(p);
      base  = {{(ACC_W-OFFS_W-16){offset[OFFS_W-1]}}, offset, 16'b0};
      acc   = rising ? (base + $signed({2'b00, prod})) : (base - $signed({2'b00, prod}));
      whole = acc[ACC_W-2:16];
      if (acc[ACC_W-1]) begin
         res = DUTY_NONE;
      end else if (whole > (ACC_W-17)'(DUTY_FULL)) begin
         res = DUTY_FULL;
      end else begin
         res = whole[DUTY_W-1:0];
      end
      return res;
   endfunction

endpackage

### design/hwrgb_colour.sv
// hue wheel lookup and the held colour registers
module hwrgb_colour (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  hwrgb_pkg::sample_type value,
   output hwrgb_pkg::colour_type colour
);
   import hwrgb_pkg::*;

   colour_type held_ff;
   colour_type held_in;
   colour_type wheel;

   always_comb begin
      wheel = held_ff;
      if (value <= SEG0_TOP) begin
         wheel.red   = DUTY_FULL;
         wheel.green = ramp(OFFS_ZERO, 1'b1, SLOPE_008, value);
         wheel.blue  = DUTY_NONE;
      end else if (value <= SEG1_TOP) begin
         wheel.red   = ramp(OFFS_RED_FALL, 1'b0, SLOPE_008, value);
         wheel.green = DUTY_FULL;
         wheel.blue  = DUTY_NONE;
      end else if (value <= SEG2_TOP) begin
         wheel.red   = DUTY_NONE;
         wheel.green = DUTY_FULL;
         wheel.blue  = ramp(OFFS_BLU_RISE, 1'b1, SLOPE_05714, value);
      end else if (value <= SEG3_TOP) begin
         wheel.red   = DUTY_NONE;
         wheel.green = ramp(OFFS_GRN_FALL, 1'b0, SLOPE_05714, value);
         wheel.blue  = DUTY_FULL;
      end else if (value <= SEG4_TOP) begin
         wheel.red   = ramp(OFFS_RED_RISE, 1'b1, SLOPE_005, value);
         wheel.green = DUTY_NONE;
         wheel.blue  = DUTY_FULL;
      end else if (value <= SEG5_TOP) begin
         wheel.red   = DUTY_FULL;
         wheel.green = DUTY_NONE;
         wheel.blue  = ramp(OFFS_BLU_FALL, 1'b0, SLOPE_005, value);
      end
      // beyond the wheel: colour kept
   end

   assign held_in = load ? wheel : held_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else begin
         held_ff <= held_in;
      end
   end

   assign colour = held_ff;

endmodule

### design/hue_wheel_rgb_from_sample_window.sv
// top level: sample window tracking, hue wheel colour result and stream handshake
// Samples arrive one per beat on req_ and are grouped into windows of
// WINDOW_LEN (6) beats. The first sample of a window sets the kept value;
// each later sample below split_level replaces it when smaller, and each
// one at or above split_level replaces it when larger. On the last beat of a
// window the kept value is registered; when the result stage is free it is
// mapped through the six-segment hue wheel into red, green and blue duty
// values (0..100 percent), which appear as one rsp_ beat. A kept value above
// 10000 repeats the previous colour. The block takes one sample every cycle
// unless a window end waits on a stalled result; the two registers between
// the sides (window end stage and result stage) let samples keep flowing
// while a result waits. csr_wdata sets split_level (reset 5000); the user
// must write it only while the block is idle, which the block does not enforce.
module hue_wheel_rgb_from_sample_window (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_wen,
   input  logic [13:0] csr_wdata,     // split_level
   // sample stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,     // [13:0] sample, [15:14] zero
   // colour stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata      // [6:0] red_duty, [13:7] green_duty,
                                      // [20:14] blue_duty, [23:21] zero
);
   import hwrgb_pkg::*;

   sample_type  split_ff, split_in;
   win_pos_type pos_ff, pos_in;
   sample_type  kept_ff, kept_in;
   logic        end_valid_ff, end_valid_in;   // window end stage
   sample_type  end_value_ff, end_value_in;
   logic        rsp_valid_ff, rsp_valid_in;

   sample_type  sample;
   logic        req_beat;
   logic        last_beat;
   logic        rsp_free;
   logic        end_move;
   colour_type  colour;

   assign sample    = req_tdata[SAMPLE_W-1:0];
   assign rsp_free  = !rsp_valid_ff || rsp_tready;
   assign end_move  = end_valid_ff && rsp_free;
   assign req_tready = !end_valid_ff || rsp_free;
   assign req_beat  = req_tvalid && req_tready;
   assign last_beat = (pos_ff == win_pos_type'(WINDOW_LEN - 1));

   // split level register
   assign split_in = csr_wen ? csr_wdata : split_ff;

   // running min or max over the window
   always_comb begin
      kept_in = kept_ff;
      pos_in  = pos_ff;
      if (req_beat) begin
         if (pos_ff == '0) begin
            kept_in = sample;
         end else if (sample < split_ff) begin
            if (sample < kept_ff) begin
               kept_in = sample;
            end
         end else begin
            if (sample > kept_ff) begin
               kept_in = sample;
            end
         end
         pos_in = last_beat ? '0 : pos_ff + win_pos_type'(1);
      end
   end

   // window end stage
   always_comb begin
      end_valid_in = end_valid_ff;
      end_value_in = end_value_ff;
      if (req_beat && last_beat) begin
         end_valid_in = 1'b1;
         end_value_in = kept_in;
      end else if (end_move) begin
         end_valid_in = 1'b0;
      end
   end

   // result stage valid; colour itself is held inside the wheel unit
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (end_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         split_ff     <= SPLIT_RESET;
         pos_ff       <= '0;
         kept_ff      <= '0;
         end_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         split_ff     <= split_in;
         pos_ff       <= pos_in;
         kept_ff      <= kept_in;
         end_valid_ff <= end_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      end_value_ff <= end_value_in;
   end

   hwrgb_colour u_colour (
      .clock  (clock),
      .reset  (reset),
      .load   (end_move),
      .value  (end_value_ff),
      .colour (colour)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, colour.blue, colour.green, colour.red};

`ifndef SYNTHESIS
   // position never runs past the window
   assert property (@(posedge clock) disable iff (reset)
      pos_ff <= win_pos_type'(WINDOW_LEN - 1))
      else $error("window position out of range");

   // a waiting window end keeps its value
   assert property (@(posedge clock) disable iff (reset)
      end_valid_ff && !rsp_free |=> end_valid_ff && $stable(end_value_ff))
      else $error("window end stage lost its value");

   // a new result only follows a window end
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(end_valid_ff))
      else $error("result without window end");

   // duty values stay within percent range
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (colour.red <= DUTY_FULL) && (colour.green <= DUTY_FULL)
                       && (colour.blue <= DUTY_FULL))
      else $error("duty above full scale");
`endif

endmodule
